>>> rtl/sdi_pkg.sv
// Shared types, widths and helper functions of the scanline depth interpolator.
// No dependencies; every other file in the block imports this package.
package sdi_pkg;

    // Fixed field widths of the query and result ports.
    localparam int ROW_W   = 10;
    localparam int DEPTH_W = 16;

    // Number of image rows and width of meaningful depth bits.
    localparam int ROW_COUNT  = 1024;
    localparam int DEPTH_BITS = 16;

    // Datapath widths that follow from the field widths.
    localparam int PROD_W = DEPTH_W + ROW_W;
    localparam int DEN_W  = PROD_W + 1;
    localparam int ZZ_W   = 2 * DEPTH_W;
    localparam int NUM_W  = ZZ_W + ROW_W;
    localparam int Q_W    = DEPTH_W;

    // Front end stages, one stage per quotient bit, and the output register.
    localparam int FRONT_STAGES = 3;
    localparam int LATENCY      = FRONT_STAGES + Q_W + 1;

    localparam logic [16:0] ROW_MAX = 17'(ROW_COUNT - 1);

    localparam logic [31:0] DEPTH_MASK_32 =
        (DEPTH_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << DEPTH_BITS) - 64'd1);
    localparam logic [DEPTH_W-1:0] DEPTH_MASK = DEPTH_MASK_32[DEPTH_W-1:0];

    // Control that travels alongside the arithmetic through the pipeline.
    typedef struct packed {
        logic               valid;
        logic               fill;
        logic               zero;
        logic [DEPTH_W-1:0] fill_depth;
    } ctl_t;

    // Saturate a row to the last row of the image.
    function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] r);
        logic [16:0] wide;
        begin
            wide = 17'(r);
            clamp_row = (wide > ROW_MAX) ? ROW_MAX[ROW_W-1:0] : r;
        end
    endfunction

endpackage

>>> rtl/sdi_front.sv
// Front end of the interpolator: row saturation, case selection, the products
// and the numerator and denominator. Three register stages; uses sdi_pkg.
module sdi_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [sdi_pkg::ROW_W-1:0]     query_row,
    input  logic [sdi_pkg::ROW_W-1:0]     upper_row,
    input  logic [sdi_pkg::DEPTH_W-1:0]   upper_depth,
    input  logic [sdi_pkg::ROW_W-1:0]     lower_row,
    input  logic [sdi_pkg::DEPTH_W-1:0]   lower_depth,
    output logic [sdi_pkg::NUM_W-1:0]     num,
    output logic [sdi_pkg::DEN_W-1:0]     den,
    output sdi_pkg::ctl_t                 ctl
);
    import sdi_pkg::*;

    logic [ROW_W-1:0]   r_c;
    logic [ROW_W-1:0]   ru_c;
    logic [ROW_W-1:0]   rl_c;
    logic [DEPTH_W-1:0] zu_c;
    logic [DEPTH_W-1:0] zl_c;
    logic               below_c;
    logic               above_c;

    logic               valid_s1_reg;
    logic               fill_s1_reg;
    logic [DEPTH_W-1:0] fdep_s1_reg;
    logic [DEPTH_W-1:0] zu_s1_reg;
    logic [DEPTH_W-1:0] zl_s1_reg;
    logic [ROW_W-1:0]   dlo_s1_reg;
    logic [ROW_W-1:0]   dhi_s1_reg;
    logic [ROW_W-1:0]   dspan_s1_reg;

    logic               valid_s2_reg;
    logic               fill_s2_reg;
    logic [DEPTH_W-1:0] fdep_s2_reg;
    logic [PROD_W-1:0]  plo_s2_reg;
    logic [PROD_W-1:0]  phi_s2_reg;
    logic [ZZ_W-1:0]    zz_s2_reg;
    logic [ROW_W-1:0]   dspan_s2_reg;

    logic               valid_s3_reg;
    logic               fill_s3_reg;
    logic               zero_s3_reg;
    logic [DEPTH_W-1:0] fdep_s3_reg;
    logic [NUM_W-1:0]   num_s3_reg;
    logic [DEN_W-1:0]   den_s3_reg;
    logic [DEN_W-1:0]   den_next;

    // Stage 1: saturate rows, mask depths and decide between fill and interpolation.
    always_comb
    begin
        r_c     = clamp_row(query_row);
        ru_c    = clamp_row(upper_row);
        rl_c    = clamp_row(lower_row);
        zu_c    = upper_depth & DEPTH_MASK;
        zl_c    = lower_depth & DEPTH_MASK;
        below_c = (r_c >= rl_c);
        above_c = (r_c < ru_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
            valid_s3_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= take;
            valid_s2_reg <= valid_s1_reg;
            valid_s3_reg <= valid_s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_s1_reg  <= below_c || above_c;
        fdep_s1_reg  <= below_c ? zl_c : zu_c;
        zu_s1_reg    <= zu_c;
        zl_s1_reg    <= zl_c;
        dlo_s1_reg   <= rl_c - r_c;
        dhi_s1_reg   <= r_c - ru_c;
        dspan_s1_reg <= rl_c - ru_c;
    end

    // Stage 2: the two weighted depths and the depth product.
    always_ff @(posedge clk)
    begin
        fill_s2_reg  <= fill_s1_reg;
        fdep_s2_reg  <= fdep_s1_reg;
        plo_s2_reg   <= PROD_W'(zl_s1_reg) * PROD_W'(dlo_s1_reg);
        phi_s2_reg   <= PROD_W'(zu_s1_reg) * PROD_W'(dhi_s1_reg);
        zz_s2_reg    <= ZZ_W'(zu_s1_reg) * ZZ_W'(zl_s1_reg);
        dspan_s2_reg <= dspan_s1_reg;
    end

    // Stage 3: denominator sum with its zero test, and the full numerator.
    assign den_next = DEN_W'(plo_s2_reg) + DEN_W'(phi_s2_reg);

    always_ff @(posedge clk)
    begin
        fill_s3_reg <= fill_s2_reg;
        fdep_s3_reg <= fdep_s2_reg;
        zero_s3_reg <= (den_next == '0);
        den_s3_reg  <= den_next;
        num_s3_reg  <= NUM_W'(zz_s2_reg) * NUM_W'(dspan_s2_reg);
    end

    assign num            = num_s3_reg;
    assign den            = den_s3_reg;
    assign ctl.valid      = valid_s3_reg;
    assign ctl.fill       = fill_s3_reg;
    assign ctl.zero       = zero_s3_reg;
    assign ctl.fill_depth = fdep_s3_reg;

endmodule

>>> rtl/sdi_divider.sv
// Pipelined restoring divider: one quotient bit per register stage, most
// significant bit first. Uses sdi_pkg for widths and the control struct.
module sdi_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sdi_pkg::NUM_W-1:0]   num,
    input  logic [sdi_pkg::DEN_W-1:0]   den,
    input  sdi_pkg::ctl_t               ctl_in,
    output logic [sdi_pkg::Q_W-1:0]     quotient,
    output sdi_pkg::ctl_t               ctl_out
);
    import sdi_pkg::*;

    logic [NUM_W-1:0] rem_reg   [0:Q_W-1];
    logic [DEN_W-1:0] den_reg   [0:Q_W-1];
    logic [Q_W-1:0]   q_reg     [0:Q_W-1];
    ctl_t             ctl_reg   [0:Q_W-1];
    logic             valid_reg [0:Q_W-1];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_step
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [Q_W-1:0]   q_in;
            ctl_t             ctl_s;
            logic             valid_in;
            logic [NUM_W-1:0] trial;
            logic             fits;

            if (k == 0)
            begin : g_head
                assign rem_in   = num;
                assign den_in   = den;
                assign q_in     = '0;
                assign ctl_s    = ctl_in;
                assign valid_in = ctl_in.valid;
            end
            else
            begin : g_body
                assign rem_in   = rem_reg[k-1];
                assign den_in   = den_reg[k-1];
                assign q_in     = q_reg[k-1];
                assign ctl_s    = ctl_reg[k-1];
                assign valid_in = valid_reg[k-1];
            end

            // The quotient never exceeds the larger depth, so the divisor
            // shifted by the bit weight always fits in the remainder width.
            assign trial = NUM_W'(den_in) << (Q_W - 1 - k);
            assign fits  = (rem_in >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else
                begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= fits ? (rem_in - trial) : rem_in;
                den_reg[k] <= den_in;
                ctl_reg[k] <= ctl_s;
                q_reg[k]   <= q_in | (Q_W'(fits) << (Q_W - 1 - k));
            end
        end
    endgenerate

    always_comb
    begin
        ctl_out       = ctl_reg[Q_W-1];
        ctl_out.valid = valid_reg[Q_W-1];
    end

    assign quotient = q_reg[Q_W-1];

endmodule

>>> rtl/scanline_depth_interpolator.sv
// Top level of the scanline depth interpolator: front end, pipelined divider
// and output register. Depends on sdi_pkg, sdi_front and sdi_divider.
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  query     start, busy          query_row, upper_row, upper_depth,
//                                 lower_row, lower_depth
//  result    done (one cycle)     depth_out, depth_valid
//
// A query is transferred at every rising edge with start high and busy low.
// Busy is never raised, so a new query may be transferred in every cycle.
// Each query gives exactly one result, shown for one cycle with done high;
// between transfer and result lie three front end stages, sixteen divider
// stages (one quotient bit each) and the output register.
// The asynchronous reset clears every stage valid bit and done; queries in flight are dropped.
// The receiver cannot stall, so results leave in transfer order at full rate.
module scanline_depth_interpolator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sdi_pkg::ROW_W-1:0]     query_row,
    input  logic [sdi_pkg::ROW_W-1:0]     upper_row,
    input  logic [sdi_pkg::DEPTH_W-1:0]   upper_depth,
    input  logic [sdi_pkg::ROW_W-1:0]     lower_row,
    input  logic [sdi_pkg::DEPTH_W-1:0]   lower_depth,
    output logic                          done,
    output logic [sdi_pkg::DEPTH_W-1:0]   depth_out,
    output logic                          depth_valid
);
    import sdi_pkg::*;

    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;
    ctl_t               front_ctl;
    ctl_t               div_ctl;
    logic [Q_W-1:0]     quotient;
    logic               take;

    logic               done_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic               depth_valid_reg;
    logic [DEPTH_W-1:0] depth_next;

    // The pipeline advances every cycle, so the block is always ready.
    assign busy = 1'b0;
    assign take = start && !busy;

    sdi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .query_row   (query_row),
        .upper_row   (upper_row),
        .upper_depth (upper_depth),
        .lower_row   (lower_row),
        .lower_depth (lower_depth),
        .num         (num),
        .den         (den),
        .ctl         (front_ctl)
    );

    sdi_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .num      (num),
        .den      (den),
        .ctl_in   (front_ctl),
        .quotient (quotient),
        .ctl_out  (div_ctl)
    );

    // Fill cases pass the chosen sample depth; a zero denominator gives zero
    // with the valid flag low; otherwise the quotient is the interpolated depth.
    always_comb
    begin
        if (div_ctl.fill)
        begin
            depth_next = div_ctl.fill_depth;
        end
        else if (div_ctl.zero)
        begin
            depth_next = '0;
        end
        else
        begin
            depth_next = quotient & DEPTH_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        depth_reg       <= depth_next;
        depth_valid_reg <= div_ctl.fill || !div_ctl.zero;
    end

    assign done        = done_reg;
    assign depth_out   = depth_reg;
    assign depth_valid = depth_valid_reg;

`ifndef NO_ASSERTIONS
    // Every transferred query produces its result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after query transfer");

    // No result appears without a matching transferred query.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching query");

    // A result flagged invalid always carries a zero depth.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !depth_valid) |-> (depth_out == '0))
        else $error("invalid result with nonzero depth");
`endif

endmodule

>>> sim/sdi_depth_checker.sv
// Checker for the scanline depth interpolator: watches the query and result channels,
// predicts each result and compares it against what the block returns.
// Depends on sdi_pkg for the field widths, the row count and the depth width.
`timescale 1ns / 100ps

module sdi_depth_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [sdi_pkg::ROW_W-1:0]     query_row,
    input  logic [sdi_pkg::ROW_W-1:0]     upper_row,
    input  logic [sdi_pkg::DEPTH_W-1:0]   upper_depth,
    input  logic [sdi_pkg::ROW_W-1:0]     lower_row,
    input  logic [sdi_pkg::DEPTH_W-1:0]   lower_depth,
    input  logic                          done,
    input  logic [sdi_pkg::DEPTH_W-1:0]   depth_out,
    input  logic                          depth_valid,
    output int                            error_count,
    output int                            pending
);
    import sdi_pkg::*;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               valid;
    } depth_result_t;

    depth_result_t expected_depths[$];

    function automatic logic [ROW_W-1:0] saturate_row(input logic [ROW_W-1:0] row);
        if (int'(row) > ROW_COUNT - 1)
            return ROW_W'(ROW_COUNT - 1);
        return row;
    endfunction

    // Fill above the upper sample or at/below the lower one; otherwise the
    // depth follows from inverse depth being linear in the row.
    function automatic depth_result_t predict_depth(
        input logic [ROW_W-1:0]   qr,
        input logic [ROW_W-1:0]   ur,
        input logic [DEPTH_W-1:0] ud,
        input logic [ROW_W-1:0]   lr,
        input logic [DEPTH_W-1:0] ld
    );
        logic [63:0]   r, ru, rl, zu, zl, den, quo, mask;
        depth_result_t res;
        mask      = (64'd1 << DEPTH_BITS) - 64'd1;
        r         = 64'(saturate_row(qr));
        ru        = 64'(saturate_row(ur));
        rl        = 64'(saturate_row(lr));
        zu        = 64'(ud) & mask;
        zl        = 64'(ld) & mask;
        res.valid = 1'b1;
        if (r >= rl)
        begin
            quo = zl;
        end
        else if (r < ru)
        begin
            quo = zu;
        end
        else
        begin
            den = zl * (rl - r) + zu * (r - ru);
            if (den == 64'd0)
            begin
                quo       = 64'd0;
                res.valid = 1'b0;
            end
            else
            begin
                quo = (zu * zl * (rl - ru)) / den;
            end
        end
        res.depth = quo[DEPTH_W-1:0] & mask[DEPTH_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        depth_result_t want;
        if (!rst_n)
        begin
            expected_depths.delete();
            error_count = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_depths.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "result with no query outstanding: depth %0d valid %0b",
                        depth_out, depth_valid));
                end
                else
                begin
                    want = expected_depths.pop_front();
                    if (depth_out !== want.depth)
                        report_mismatch($sformatf("depth_out %0d, expected %0d",
                                                  depth_out, want.depth));
                    if (depth_valid !== want.valid)
                        report_mismatch($sformatf("depth_valid %0b, expected %0b",
                                                  depth_valid, want.valid));
                end
            end
            if (start && !busy)
                expected_depths.push_back(predict_depth(query_row, upper_row, upper_depth,
                                                        lower_row, lower_depth));
            pending <= expected_depths.size();
        end
    end

endmodule

>>> sim/scanline_depth_interpolator_tb.sv
// Top of the scanline depth interpolator testbench: clock, reset, query stimulus and verdict.
// Depends on sdi_pkg, the block itself and sdi_depth_checker, which checks every result.
`timescale 1ns / 100ps

module scanline_depth_interpolator_tb;
    import sdi_pkg::*;

    // Random queries after the directed ones, spread evenly over the phases.
    localparam int QUERY_COUNT = 1500;
    localparam int PHASE_COUNT = 4;
    // The longest run of idle cycles the sender may insert before one query.
    localparam int MAX_GAP     = 40;
    // Cycles without any transfer or result before the run is declared hung.
    localparam int STALL_LIMIT = 8 * (MAX_GAP + LATENCY);

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [ROW_W-1:0]   query_row;
    logic [ROW_W-1:0]   upper_row;
    logic [DEPTH_W-1:0] upper_depth;
    logic [ROW_W-1:0]   lower_row;
    logic [DEPTH_W-1:0] lower_depth;
    logic               done;
    logic [DEPTH_W-1:0] depth_out;
    logic               depth_valid;

    int error_count;
    int pending;
    // Percentage of cycles in which the sender holds back; set per phase.
    int idle_pct;

    scanline_depth_interpolator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .query_row   (query_row),
        .upper_row   (upper_row),
        .upper_depth (upper_depth),
        .lower_row   (lower_row),
        .lower_depth (lower_depth),
        .done        (done),
        .depth_out   (depth_out),
        .depth_valid (depth_valid)
    );

    // The checker sees exactly what the block sees and predicts each result.
    sdi_depth_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .query_row   (query_row),
        .upper_row   (upper_row),
        .upper_depth (upper_depth),
        .lower_row   (lower_row),
        .lower_depth (lower_depth),
        .done        (done),
        .depth_out   (depth_out),
        .depth_valid (depth_valid),
        .error_count (error_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offers one query and returns once it has been transferred. All inputs
    // change at the falling edge only, and start gets a single assignment per
    // edge, so back-to-back queries keep start high without a glitch. During
    // idle cycles the payload carries junk that the block must ignore.
    task automatic send_query(
        input logic [ROW_W-1:0]   qr,
        input logic [ROW_W-1:0]   ur,
        input logic [DEPTH_W-1:0] ud,
        input logic [ROW_W-1:0]   lr,
        input logic [DEPTH_W-1:0] ld
    );
        int gap;
        bit offered;
        gap     = 0;
        offered = 1'b0;
        do
        begin
            @(negedge clk);
            if (!offered && gap < MAX_GAP && $urandom_range(99, 0) < idle_pct)
            begin
                start       <= 1'b0;
                query_row   <= ROW_W'($urandom());
                upper_row   <= ROW_W'($urandom());
                upper_depth <= DEPTH_W'($urandom());
                lower_row   <= ROW_W'($urandom());
                lower_depth <= DEPTH_W'($urandom());
                gap++;
            end
            else
            begin
                start       <= 1'b1;
                query_row   <= qr;
                upper_row   <= ur;
                upper_depth <= ud;
                lower_row   <= lr;
                lower_depth <= ld;
                offered     = 1'b1;
            end
            @(posedge clk);
        end while (!(offered && !busy));
    endtask

    // Depths lean toward zero, the maximum and small values, where the
    // divider and the zero-denominator logic are most likely to slip.
    function automatic logic [DEPTH_W-1:0] pick_depth();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 8)
            return '0;
        if (sel < 16)
            return '1;
        if (sel < 26)
            return DEPTH_W'($urandom_range(255, 1));
        return DEPTH_W'($urandom());
    endfunction

    // Most queries are well formed: the upper sample above the lower one and
    // the query row between them, so the interpolation path does the work.
    // The rest covers the fill cases, swapped and equal sample rows, zero
    // denominators and unconstrained noise.
    task automatic send_random_query();
        int sel;
        int qr, ur, lr;
        logic [DEPTH_W-1:0] ud, ld;
        sel = $urandom_range(99, 0);
        ud  = pick_depth();
        ld  = pick_depth();
        ur  = $urandom_range(ROW_COUNT - 2, 0);
        lr  = $urandom_range(ROW_COUNT - 1, ur + 1);
        qr  = $urandom_range(lr - 1, ur);
        if (sel < 65)
        begin
            // Interpolation between the samples; sometimes right on the upper row.
            if ($urandom_range(9, 0) == 0)
                qr = ur;
        end
        else if (sel < 75)
        begin
            // Fill above the upper sample, at the lower sample or below it, unless the random row falls between.
            qr = $urandom_range(ROW_COUNT - 1, 0);
            if ($urandom_range(3, 0) == 0)
                qr = lr;
        end
        else if (sel < 82)
        begin
            // Sample rows out of order: no interpolation at all.
            lr = $urandom_range(ROW_COUNT - 2, 0);
            ur = $urandom_range(ROW_COUNT - 1, lr + 1);
            qr = $urandom_range(ROW_COUNT - 1, 0);
        end
        else if (sel < 88)
        begin
            // Both samples on one row, with the query on it or next to it.
            lr = ur;
            qr = $urandom_range((ur + 1 > ROW_COUNT - 1) ? ROW_COUNT - 1 : ur + 1,
                                (ur == 0) ? 0 : ur - 1);
        end
        else if (sel < 94)
        begin
            // Zero lower depth: the denominator vanishes when the upper depth
            // is zero too or the query lies on the upper row.
            ld = '0;
            if ($urandom_range(1, 0) == 0)
                ud = '0;
            else
                qr = ur;
        end
        else
        begin
            qr = $urandom_range(ROW_COUNT - 1, 0);
            ur = $urandom_range(ROW_COUNT - 1, 0);
            lr = $urandom_range(ROW_COUNT - 1, 0);
            ud = DEPTH_W'($urandom());
            ld = DEPTH_W'($urandom());
        end
        send_query(ROW_W'(qr), ROW_W'(ur), ud, ROW_W'(lr), ld);
    endtask

    // Stimulus: reset, a directed set, random phases with different sender
    // idling, then a drain and the verdict.
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        query_row   = '0;
        upper_row   = '0;
        upper_depth = '0;
        lower_row   = '0;
        lower_depth = '0;
        idle_pct    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // All fields at their minimum, then at their maximum.
        send_query(10'd0,    10'd0,    16'd0,     10'd0,    16'd0);
        send_query(10'd1023, 10'd1023, 16'hFFFF,  10'd1023, 16'hFFFF);
        // Plain interpolation, on the upper row and just above the lower row.
        send_query(10'd100,  10'd50,   16'd1000,  10'd200,  16'd3000);
        send_query(10'd50,   10'd50,   16'd1000,  10'd200,  16'd3000);
        send_query(10'd199,  10'd50,   16'd1000,  10'd200,  16'd3000);
        // Fills: above the upper sample, at the lower sample, below it.
        send_query(10'd10,   10'd50,   16'd1000,  10'd200,  16'd3000);
        send_query(10'd200,  10'd50,   16'd1000,  10'd200,  16'd3000);
        send_query(10'd500,  10'd50,   16'd1000,  10'd200,  16'd3000);
        // Zero denominator: both depths zero, or zero lower depth on the upper row.
        send_query(10'd100,  10'd50,   16'd0,     10'd200,  16'd0);
        send_query(10'd50,   10'd50,   16'd1234,  10'd200,  16'd0);
        // One depth zero with a nonzero denominator gives a valid zero.
        send_query(10'd120,  10'd50,   16'd1234,  10'd200,  16'd0);
        send_query(10'd120,  10'd50,   16'd0,     10'd200,  16'd4321);
        // Sample rows out of order.
        send_query(10'd200,  10'd300,  16'd700,   10'd100,  16'd900);
        send_query(10'd50,   10'd300,  16'd700,   10'd100,  16'd900);
        send_query(10'd100,  10'd300,  16'd700,   10'd100,  16'd900);
        // Equal sample rows: on the row, just above and just below it.
        send_query(10'd400,  10'd400,  16'd2222,  10'd400,  16'd3333);
        send_query(10'd399,  10'd400,  16'd2222,  10'd400,  16'd3333);
        send_query(10'd401,  10'd400,  16'd2222,  10'd400,  16'd3333);
        // Widest span with extreme depths, and the narrowest span.
        send_query(10'd512,  10'd0,    16'hFFFF,  10'd1023, 16'hFFFF);
        send_query(10'd1022, 10'd0,    16'hFFFF,  10'd1023, 16'd1);
        send_query(10'd1,    10'd0,    16'd1,     10'd1023, 16'hFFFF);
        send_query(10'd0,    10'd0,    16'd5000,  10'd1,    16'd6000);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                1:       idle_pct = 85;
                2:       idle_pct = 25;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < QUERY_COUNT / PHASE_COUNT; n++)
                send_random_query();
        end

        @(negedge clk);
        start <= 1'b0;
        // Every query must come back; the watchdog ends a run that hangs here.
        while (pending != 0)
            @(negedge clk);
        // Go on waiting so that a stray extra result would still be seen.
        repeat (LATENCY + 4) @(negedge clk);
        if (error_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: a cycle counts as quiet when no query is transferred and no
    // result appears. Too many quiet cycles in a row mean the block hung.
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
